>>> hw/rtl/gbs_pkg.sv
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared types, constants and corner helpers for the box suppression block.
// ----------------------------------------------------------------------------
`default_nettype none

package gbs_pkg;

   localparam int MAX_KEPT  = 64;
   localparam int KEPT_AW   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CNT_W     = $clog2(MAX_KEPT + 1);
   localparam int SLOT_W    = 6;
   localparam int THR_W     = 9;
   localparam int CLASS_W   = 7;
   localparam int COORD_W   = 16;
   localparam int SPAN_W    = COORD_W + 1;
   localparam int AREA_W    = 32;
   localparam int INTER_W   = 2 * SPAN_W;
   localparam int UNION_W   = INTER_W + 1;
   localparam int PROD_W    = UNION_W + THR_W + 1;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_IOU_THRESHOLD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLASS_AGNOSTIC = 2'd1;

   localparam logic [THR_W-1:0] THR_RESET = 9'd115;

   typedef struct packed {
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] top;
      logic signed [COORD_W-1:0] right;
      logic signed [COORD_W-1:0] bottom;
      logic [CLASS_W-1:0]        cls;
      logic [AREA_W-1:0]         area;
   } box_type;

   function automatic logic [SPAN_W-1:0] span_f(input logic signed [COORD_W-1:0] lo,
                                                 input logic signed [COORD_W-1:0] hi);
      logic [SPAN_W-1:0] d;
      d = {hi[COORD_W-1], hi} - {lo[COORD_W-1], lo};
      return (hi > lo) ? d : '0;
   endfunction

   function automatic logic signed [COORD_W-1:0] smax_f(input logic signed [COORD_W-1:0] a,
                                                        input logic signed [COORD_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic signed [COORD_W-1:0] smin_f(input logic signed [COORD_W-1:0] a,
                                                        input logic signed [COORD_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/gbs_store.sv
// ----------------------------------------------------------------------------
// gbs_store
// Kept box list: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gbs_store import gbs_pkg::*; (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [KEPT_AW-1:0] wr_addr,
   input  box_type            wr_data,
   input  logic               rd_en,
   input  logic [KEPT_AW-1:0] rd_addr,
   output box_type            rd_data
);

   box_type mem [MAX_KEPT];
   box_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/gbs_iou.sv
// ----------------------------------------------------------------------------
// gbs_iou
// Pipelined overlap unit: one kept entry per cycle against the current box.
// ----------------------------------------------------------------------------
`default_nettype none

module gbs_iou import gbs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             ent_valid,
   input  box_type          ent,
   input  box_type          box,
   input  logic [THR_W-1:0] thr,
   input  logic             agnostic,
   output logic             hit_valid,
   output logic             hit,
   output logic             busy
);

   // stage a: intersection spans
   logic              a_valid_in, a_valid_ff;
   logic [SPAN_W-1:0] ix_in, iy_in, ix_ff, iy_ff;
   logic [AREA_W-1:0] a_karea_ff;
   // stage b: intersection area
   logic               b_valid_ff;
   logic [INTER_W-1:0] inter_in, b_inter_ff;
   logic [AREA_W-1:0]  b_karea_ff;
   // stage c: union
   logic               c_valid_ff;
   logic [UNION_W-1:0] uni_in, uni_ff;
   logic [INTER_W-1:0] c_inter_ff;
   // stage d: threshold times union
   logic                     d_valid_ff;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   logic [INTER_W-1:0]       d_inter_ff;

   assign a_valid_in = ent_valid && (agnostic || (ent.cls == box.cls));
   assign ix_in      = span_f(smax_f(box.left, ent.left), smin_f(box.right, ent.right));
   assign iy_in      = span_f(smax_f(box.top, ent.top), smin_f(box.bottom, ent.bottom));
   assign inter_in   = ix_ff * iy_ff;
   assign uni_in     = {3'b000, box.area} + {3'b000, b_karea_ff} - {1'b0, b_inter_ff};
   assign prod_in    = $signed({1'b0, thr}) * $signed(uni_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      ix_ff      <= ix_in;
      iy_ff      <= iy_in;
      a_karea_ff <= ent.area;
      b_inter_ff <= inter_in;
      b_karea_ff <= a_karea_ff;
      uni_ff     <= uni_in;
      c_inter_ff <= b_inter_ff;
      prod_ff    <= prod_in;
      d_inter_ff <= c_inter_ff;
   end

   // a negative product reads as a huge unsigned value, so it never suppresses
   assign hit_valid = d_valid_ff;
   assign hit       = !prod_ff[PROD_W-1] &&
                      ({2'b00, d_inter_ff, 8'h00} > prod_ff[PROD_W-2:0]);
   assign busy      = a_valid_ff || b_valid_ff || c_valid_ff || d_valid_ff;

endmodule

`default_nettype wire

>>> hw/rtl/greedy_box_suppression.sv
// ----------------------------------------------------------------------------
// greedy_box_suppression
// Greedy non-maximum suppression over a kept list of score-sorted boxes.
// ----------------------------------------------------------------------------
// One box is taken at a time and req_stall stays high while it is worked on.
// From its transfer to its result a box passes through these steps: the area
// step forms its area, the scan streams the kept list through the overlap
// pipeline (one read per cycle from the list memory) and then ends, the drain
// step waits for that pipeline to empty, and the post step writes the result;
// the block then returns to idle to take the next box. The result sits in an
// output register, so the next box is taken while an earlier result waits on
// rsp_stall; a box whose result is ready waits in the post step for that slot.
// The kept list holds 64 boxes and needs no clearing pass after reset.

`default_nettype none

module greedy_box_suppression import gbs_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_frame_start,
   input  logic signed [COORD_W-1:0]   req_left,
   input  logic signed [COORD_W-1:0]   req_top,
   input  logic signed [COORD_W-1:0]   req_right,
   input  logic signed [COORD_W-1:0]   req_bottom,
   input  logic [CLASS_W-1:0]          req_class_id,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_kept,
   output logic [SLOT_W-1:0]           rsp_slot,
   output logic                        rsp_list_full,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [THR_W-1:0]            csr_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_AREA  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]          state_ff, state_in;
   box_type             box_ff, box_in;
   logic [SPAN_W-1:0]   w_ff, w_in, h_ff, h_in;
   logic [INTER_W-1:0]  area_full;
   logic [CNT_W-1:0]    count_ff, count_in, iss_ff, iss_in;
   logic                supp_ff, supp_in;
   logic                rd_en, rd_valid_ff;
   logic                wr_en;
   logic [THR_W-1:0]    thr_ff, thr_in;
   logic                agn_ff, agn_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_kept_ff, rsp_kept_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic                rsp_full_ff, rsp_full_in;
   box_type             rd_data;
   logic                hit_valid, hit, iou_busy;

   assign area_full = w_ff * h_ff;

   always_comb begin
      state_in     = state_ff;
      box_in       = box_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      count_in     = count_ff;
      iss_in       = iss_ff;
      supp_in      = supp_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      thr_in       = thr_ff;
      agn_in       = agn_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kept_in  = rsp_kept_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_full_in  = rsp_full_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (hit_valid && hit) begin
         supp_in = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               box_in.left   = req_left;
               box_in.top    = req_top;
               box_in.right  = req_right;
               box_in.bottom = req_bottom;
               box_in.cls    = req_class_id;
               w_in          = span_f(req_left, req_right);
               h_in          = span_f(req_top, req_bottom);
               supp_in       = 1'b0;
               iss_in        = '0;
               if (req_frame_start) begin
                  count_in = '0;
               end
               state_in = ST_AREA;
            end
         end
         ST_AREA: begin
            box_in.area = area_full[AREA_W-1:0];
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            if (iss_ff == count_ff) begin
               state_in = ST_DRAIN;
            end else begin
               rd_en  = 1'b1;
               iss_in = iss_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!rd_valid_ff && !iou_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_kept_in  = !supp_ff;
               rsp_slot_in  = '0;
               rsp_full_in  = 1'b0;
               if (!supp_ff) begin
                  if (count_ff < CNT_W'(MAX_KEPT)) begin
                     wr_en       = 1'b1;
                     rsp_slot_in = SLOT_W'(count_ff);
                     count_in    = count_ff + 1'b1;
                  end else begin
                     rsp_full_in = 1'b1;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_valid) begin
         case (csr_index)
            CSR_IOU_THRESHOLD:  thr_in = csr_data;
            CSR_CLASS_AGNOSTIC: agn_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         iss_ff       <= '0;
         supp_ff      <= 1'b0;
         rd_valid_ff  <= 1'b0;
         thr_ff       <= THR_RESET;
         agn_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         iss_ff       <= iss_in;
         supp_ff      <= supp_in;
         rd_valid_ff  <= rd_en;
         thr_ff       <= thr_in;
         agn_ff       <= agn_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      box_ff      <= box_in;
      w_ff        <= w_in;
      h_ff        <= h_in;
      rsp_kept_ff <= rsp_kept_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_full_ff <= rsp_full_in;
   end

   gbs_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[KEPT_AW-1:0]),
      .wr_data (box_ff),
      .rd_en   (rd_en),
      .rd_addr (iss_ff[KEPT_AW-1:0]),
      .rd_data (rd_data)
   );

   gbs_iou u_iou (
      .clock     (clock),
      .reset     (reset),
      .ent_valid (rd_valid_ff),
      .ent       (rd_data),
      .box       (box_ff),
      .thr       (thr_ff),
      .agnostic  (agn_ff),
      .hit_valid (hit_valid),
      .hit       (hit),
      .busy      (iou_busy)
   );

   assign req_stall     = (state_ff != ST_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kept      = rsp_kept_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_list_full = rsp_full_ff;

endmodule

`default_nettype wire

>>> hw/rtl/gbs_checker.sv
// ----------------------------------------------------------------------------
// gbs_checker
// Port-level checks on the box suppression block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gbs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_kept,
   input logic [5:0] rsp_slot,
   input logic       rsp_list_full
);

   // a held result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kept) && $stable(rsp_slot)
                                 && $stable(rsp_list_full))
      else $error("stalled result changed");

   // suppressed box reports no slot and no overflow
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kept |-> rsp_slot == 6'd0 && !rsp_list_full)
      else $error("suppressed box with slot or overflow");

   // overflow only on a kept box, and then with slot zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_list_full |-> rsp_kept && rsp_slot == 6'd0)
      else $error("overflow flag on bad result");

   // one box at a time: busy right after a transfer in
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second box taken while busy");

   // no result straight out of reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind greedy_box_suppression gbs_checker u_gbs_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_kept      (rsp_kept),
   .rsp_slot      (rsp_slot),
   .rsp_list_full (rsp_list_full)
);

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks greedy_box_suppression against a cycle-free model of greedy box
// suppression: boxes go in frame by frame with random gaps, results come out
// under random back-pressure, and every verdict is compared field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   import gbs_pkg::*;

   typedef struct {
      bit                        frame_start;
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] top;
      logic signed [COORD_W-1:0] right;
      logic signed [COORD_W-1:0] bottom;
      logic [CLASS_W-1:0]        cls;
   } box_req_type;

   typedef struct {
      bit              kept;
      bit [SLOT_W-1:0] slot;
      bit              full;
   } verdict_type;

   class verdict_board;
      verdict_type            expected_verdicts[$];
      int                     kept_l[MAX_KEPT];
      int                     kept_t[MAX_KEPT];
      int                     kept_r[MAX_KEPT];
      int                     kept_b[MAX_KEPT];
      bit [CLASS_W-1:0]       kept_cls[MAX_KEPT];
      longint unsigned        kept_area[MAX_KEPT];
      int                     kept_total;
      bit [THR_W-1:0]         threshold;
      bit                     agnostic;
      int                     mismatches;

      function new();
         kept_total = 0;
         threshold  = THR_RESET;
         agnostic   = 1'b0;
         mismatches = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [THR_W-1:0] data);
         if (idx == CSR_IOU_THRESHOLD)
            threshold = data;
         else if (idx == CSR_CLASS_AGNOSTIC)
            agnostic = data[0];
      endfunction

      function longint unsigned extent(int lo, int hi);
         return (hi > lo) ? longint'(hi - lo) : 64'd0;
      endfunction

      function void note_box(box_req_type bx);
         int              l, t, r, b;
         longint unsigned area, inter, uni;
         bit              keep;
         verdict_type     v;
         l = bx.left;
         t = bx.top;
         r = bx.right;
         b = bx.bottom;
         area = extent(l, r) * extent(t, b);
         if (bx.frame_start)
            kept_total = 0;
         keep = 1'b1;
         for (int j = 0; j < kept_total; j++) begin
            if (agnostic || kept_cls[j] == bx.cls) begin
               inter = extent((l > kept_l[j]) ? l : kept_l[j], (r < kept_r[j]) ? r : kept_r[j]) *
                       extent((t > kept_t[j]) ? t : kept_t[j], (b < kept_b[j]) ? b : kept_b[j]);
               uni = area + kept_area[j] - inter;
               if (inter * 64'd256 > longint'(threshold) * uni)
                  keep = 1'b0;
            end
         end
         v.kept = keep;
         v.slot = '0;
         v.full = 1'b0;
         if (keep) begin
            if (kept_total < MAX_KEPT) begin
               kept_l[kept_total]    = l;
               kept_t[kept_total]    = t;
               kept_r[kept_total]    = r;
               kept_b[kept_total]    = b;
               kept_cls[kept_total]  = bx.cls;
               kept_area[kept_total] = area;
               v.slot = kept_total[SLOT_W-1:0];
               kept_total++;
            end else begin
               v.full = 1'b1;
            end
         end
         expected_verdicts.insert(expected_verdicts.size(), v);
      endfunction

      function void check_verdict(bit kept, bit [SLOT_W-1:0] slot, bit full);
         verdict_type v;
         if (expected_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result transfer: kept=%0d slot=%0d full=%0d",
                        kept, slot, full);
         end else begin
            v = expected_verdicts.pop_front();
            if (v.kept !== kept || v.slot !== slot || v.full !== full) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"result mismatch: expected kept=%0d slot=%0d full=%0d, ",
                            "got kept=%0d slot=%0d full=%0d"},
                           v.kept, v.slot, v.full, kept, slot, full);
            end
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_frame_start = 1'b0;
   logic signed [COORD_W-1:0]  req_left = '0;
   logic signed [COORD_W-1:0]  req_top = '0;
   logic signed [COORD_W-1:0]  req_right = '0;
   logic signed [COORD_W-1:0]  req_bottom = '0;
   logic [CLASS_W-1:0]         req_class_id = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_kept;
   logic [SLOT_W-1:0]          rsp_slot;
   logic                       rsp_list_full;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [THR_W-1:0]           csr_data = '0;

   verdict_board board;
   bit           calm = 1'b0;
   int           hold_cycles = 0;
   int           burst_left = 0;
   int           quiet_left = 0;
   int           send_quiet = 0;
   int           boxes_sent = 0;

   greedy_box_suppression u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_frame_start (req_frame_start),
      .req_left        (req_left),
      .req_top         (req_top),
      .req_right       (req_right),
      .req_bottom      (req_bottom),
      .req_class_id    (req_class_id),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kept        (rsp_kept),
      .rsp_slot        (rsp_slot),
      .rsp_list_full   (rsp_list_full),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #10 clock = ~clock;

   initial begin
      #20_000_000;
      $display("testbench NOT OK");
      $finish;
   end

   // result side back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles--;
      end else if (burst_left > 0) begin
         rsp_stall <= 1'b1;
         burst_left--;
      end else if (calm || quiet_left > 0) begin
         rsp_stall <= 1'b0;
         if (quiet_left > 0)
            quiet_left--;
      end else if ($urandom_range(0, 11) == 0) begin
         rsp_stall <= 1'b1;
         burst_left = $urandom_range(0, 17);
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 39) == 0)
            quiet_left = $urandom_range(20, 120);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_verdict(rsp_kept, rsp_slot, rsp_list_full);
   end

   task automatic send_box(box_req_type bx);
      int gap;
      if (!calm) begin
         if (send_quiet > 0) begin
            send_quiet--;
         end else if ($urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            repeat (gap) begin
               @(negedge clock);
               req_valid <= 1'b0;
            end
            if ($urandom_range(0, 5) == 0)
               send_quiet = $urandom_range(10, 60);
         end
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_frame_start <= bx.frame_start;
      req_left        <= bx.left;
      req_top         <= bx.top;
      req_right       <= bx.right;
      req_bottom      <= bx.bottom;
      req_class_id    <= bx.cls;
      do @(posedge clock); while (req_stall);
      board.note_box(bx);
      boxes_sent++;
   endtask

   task automatic send_corners(bit fs, int l, int t, int r, int b, int cls);
      box_req_type bx;
      bx.frame_start = fs;
      bx.left        = l[COORD_W-1:0];
      bx.top         = t[COORD_W-1:0];
      bx.right       = r[COORD_W-1:0];
      bx.bottom      = b[COORD_W-1:0];
      bx.cls         = cls[CLASS_W-1:0];
      send_box(bx);
   endtask

   task automatic await_drain();
      int waited;
      waited = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.expected_verdicts.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [THR_W-1:0] data);
      await_drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      board.set_register(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic int clip16(int v);
      if (v > 32767)
         return 32767;
      if (v < -32768)
         return -32768;
      return v;
   endfunction

   task automatic run_frame(int n, bit noisy);
      int cx[4];
      int cy[4];
      int ncls, k, w, h, x, y;
      bit fs;
      ncls = $urandom_range(1, 3);
      for (int i = 0; i < 4; i++) begin
         cx[i] = int'($urandom_range(0, 60000)) - 30000;
         cy[i] = int'($urandom_range(0, 60000)) - 30000;
      end
      for (int i = 0; i < n; i++) begin
         fs = (i == 0) ? (noisy ? bit'($urandom_range(0, 1)) : 1'b1) : 1'b0;
         if ($urandom_range(0, 15) == 0) begin
            send_corners($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom,
                         $urandom_range(0, 127));
         end else begin
            k = $urandom_range(0, 3);
            w = $urandom_range(16, 3000);
            h = $urandom_range(16, 3000);
            x = cx[k] + int'($urandom_range(0, w / 2)) - w / 4;
            y = cy[k] + int'($urandom_range(0, h / 2)) - h / 4;
            send_corners(fs, clip16(x - w / 2), clip16(y - h / 2), clip16(x + w / 2),
                         clip16(y + h / 2), $urandom_range(0, ncls - 1));
         end
      end
   endtask

   // disjoint boxes that overrun the kept list, then a repeat of a stored one
   task automatic run_full_frame();
      int base_top, cls3;
      base_top = int'($urandom_range(0, 62000)) - 32768;
      cls3 = 0;
      for (int i = 0; i < 70; i++) begin
         if (i == 3)
            cls3 = $urandom_range(0, 127);
         send_corners(i == 0, -32768 + i * 900, base_top, -32768 + i * 900 + 800,
                      base_top + 800, (i == 3) ? cls3 : int'($urandom_range(0, 127)));
      end
      send_corners(0, -32768 + 3 * 900, base_top, -32768 + 3 * 900 + 800, base_top + 800,
                   cls3);
   endtask

   task automatic run_phase(int count, bit with_full, bit with_hold, bit with_pause);
      int target;
      target = boxes_sent + count;
      if (with_full)
         run_full_frame();
      while (boxes_sent < target) begin
         if (with_hold && boxes_sent > target - count / 2) begin
            hold_cycles = 400;
            with_hold = 1'b0;
         end
         if (with_pause && boxes_sent > target - count / 3) begin
            await_drain();
            with_pause = 1'b0;
         end
         run_frame($urandom_range(1, 24), $urandom_range(0, 7) == 0);
      end
   endtask

   initial begin
      board = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_corners(1, 0, 0, 160, 160, 5);
      send_corners(0, 0, 0, 160, 160, 5);
      send_corners(0, 0, 0, 160, 160, 6);
      send_corners(0, 16, 0, 176, 160, 5);
      send_corners(0, 1000, 1000, 1160, 1160, 5);
      send_corners(0, 200, 200, 100, 100, 5);
      send_corners(0, 200, 200, 100, 100, 5);
      send_corners(0, -32768, -32768, 32767, 32767, 127);
      send_corners(0, -32768, -32768, 32767, 32767, 127);
      send_corners(0, 32767, 32767, -32768, -32768, 0);

      write_csr(CSR_IOU_THRESHOLD, 9'd0);
      write_csr(CSR_CLASS_AGNOSTIC, 9'd1);
      send_corners(1, 0, 0, 160, 160, 1);
      send_corners(0, 159, 159, 400, 400, 2);
      send_corners(0, 160, 0, 320, 160, 3);
      send_corners(0, 500, 500, 500, 600, 4);

      write_csr(CSR_IOU_THRESHOLD, 9'd256);
      send_corners(1, 0, 0, 160, 160, 9);
      send_corners(0, 0, 0, 160, 160, 9);
      send_corners(0, -32768, -32768, 32767, 32767, 9);

      write_csr(CSR_IOU_THRESHOLD, 9'd128);
      write_csr(CSR_CLASS_AGNOSTIC, 9'd0);
      send_corners(1, 0, 0, 320, 160, 7);
      send_corners(0, 0, 0, 160, 160, 7);
      send_corners(0, 0, 0, 176, 160, 7);
      send_corners(0, 0, 0, 176, 160, 8);

      write_csr(CSR_IOU_THRESHOLD, THR_RESET);
      run_phase(90, 1'b0, 1'b1, 1'b0);
      write_csr(CSR_IOU_THRESHOLD, 9'd0);
      write_csr(CSR_CLASS_AGNOSTIC, 9'd1);
      run_phase(90, 1'b1, 1'b0, 1'b0);
      write_csr(CSR_IOU_THRESHOLD, 9'd256);
      write_csr(CSR_CLASS_AGNOSTIC, 9'd0);
      run_phase(90, 1'b0, 1'b0, 1'b1);
      write_csr(CSR_IOU_THRESHOLD, THR_W'($urandom_range(1, 255)));
      write_csr(CSR_CLASS_AGNOSTIC, 9'd1);
      run_phase(90, 1'b1, 1'b0, 1'b0);
      write_csr(CSR_IOU_THRESHOLD, 9'd64);
      write_csr(CSR_CLASS_AGNOSTIC, 9'd0);
      run_phase(90, 1'b0, 1'b0, 1'b0);
      write_csr(CSR_IOU_THRESHOLD, 9'd180);
      write_csr(CSR_CLASS_AGNOSTIC, 9'd1);
      calm = 1'b1;
      run_phase(60, 1'b0, 1'b0, 1'b0);

      await_drain();
      repeat (20) @(posedge clock);
      if (board.mismatches == 0 && board.expected_verdicts.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

`default_nettype wire

>>> filelist.f
hw/rtl/gbs_pkg.sv
hw/rtl/gbs_store.sv
hw/rtl/gbs_iou.sv
hw/rtl/greedy_box_suppression.sv
hw/rtl/gbs_checker.sv
tb/testbench.sv
